>>> rtl/core/ncd_pkg.sv
// Shared constants, status codes and transaction types for the central difference block.
package ncd_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int QUO_W  = DATA_W + FRAC_W;
    localparam int CNT_W  = $clog2(QUO_W + 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [DATA_W-1:0] D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] D_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [DATA_W-1:0] derivative;
        logic [1:0]        status;
        logic              last_result;
    } res_t;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] span;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
        logic [1:0]        status;
    } div_rsp_t;

endpackage

>>> rtl/core/nonuniform_central_difference.sv
// Streaming central-difference derivative over nonuniformly spaced samples.
//
// Input channel (in_valid/in_ready) takes one sample per transaction: position
// (signed Q16.16), timestamp (unsigned Q16.16) and end_of_trajectory. Output
// channel (out_valid/out_ready) gives derivative, status and last_result, one
// per input sample, in order; velocity results lag the input by one sample,
// acceleration results by two, and the final sample flushes all pending ones.
// cfg_valid/cfg_ready/cfg_data writes derivative_order (0 velocity, 1 accel);
// write it only between trajectories while the block is idle.
// One sample is handled at a time. Each division runs on a restoring divider
// that produces one quotient bit per cycle over 48 bits; a zero span skips
// the quotient bits. A sample needs one division in velocity mode and, from
// the fourth sample of a trajectory on, two in acceleration mode; a final
// sample in acceleration mode adds one more division.
// The first two samples of a trajectory need no division.
// A result sits in an output register, so a stalled receiver holds that
// transaction and the block waits before pushing another one.
// Reset clears the mode to velocity, the sample count and all history.
module nonuniform_central_difference
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] position,
    input  logic [31:0] timestamp,
    input  logic        end_of_trajectory,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] derivative,
    output logic [1:0]  status,
    output logic        last_result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DV   = 3'd1;
    localparam logic [2:0] S_DA   = 3'd2;
    localparam logic [2:0] S_E1   = 3'd3;
    localparam logic [2:0] S_DF   = 3'd4;
    localparam logic [2:0] S_E2   = 3'd5;
    localparam logic [2:0] S_E3   = 3'd6;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic                       order_reg;
    logic [1:0]                 samples_reg;
    logic                       start_reg;
    logic                       start_next;

    logic [ncd_pkg::DATA_W-1:0] p_reg;
    logic [ncd_pkg::DATA_W-1:0] t_reg;
    logic                       last_reg;
    logic [1:0]                 k_reg;
    logic                       accel_reg;

    logic [ncd_pkg::DATA_W-1:0] ph0_reg;
    logic [ncd_pkg::DATA_W-1:0] ph1_reg;
    logic [ncd_pkg::DATA_W-1:0] th0_reg;
    logic [ncd_pkg::DATA_W-1:0] th1_reg;
    logic [ncd_pkg::DATA_W-1:0] th2_reg;
    logic [ncd_pkg::DATA_W-1:0] vh0_reg;
    logic [ncd_pkg::DATA_W-1:0] vh1_reg;

    logic [ncd_pkg::DATA_W-1:0] vel_reg;
    logic [ncd_pkg::DATA_W-1:0] dq_reg;
    logic [1:0]                 dst_reg;

    ncd_pkg::div_req_t          div_req;
    ncd_pkg::div_rsp_t          div_rsp;
    ncd_pkg::res_t              em_res;
    ncd_pkg::res_t              out_res;
    logic                       em_valid;
    logic                       em_ready;
    logic                       adv_emit;

    logic                       k_ge2;
    logic                       zero_lead;
    logic                       div_item;
    logic                       need1;
    logic                       need_flush;
    logic                       in_acc;
    logic                       update;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;

    assign k_ge2      = k_reg[1];
    assign zero_lead  = ((k_reg == 2'd1) && (!accel_reg || last_reg))
                      || ((k_reg == 2'd2) && accel_reg);
    assign div_item   = k_ge2 && !(accel_reg && (k_reg == 2'd2));
    assign need1      = zero_lead || div_item;
    assign need_flush = k_ge2 && accel_reg && last_reg;

    always_comb
    begin
        em_valid = 1'b0;
        em_res   = '0;
        unique case (state_reg)
            S_E1:
            begin
                em_valid = need1;
                if (div_item)
                begin
                    em_res.derivative = dq_reg;
                    em_res.status     = dst_reg;
                end
            end
            S_E2:
            begin
                em_valid          = 1'b1;
                em_res.derivative = dq_reg;
                em_res.status     = dst_reg;
            end
            S_E3:
            begin
                em_valid           = last_reg;
                em_res.status      = ncd_pkg::ST_OK;
                em_res.last_result = 1'b1;
            end
            default:
            begin
                em_valid = 1'b0;
            end
        endcase
    end

    assign adv_emit = !em_valid || em_ready;
    assign update   = (state_reg == S_E3) && adv_emit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (samples_reg >= 2'd2) ? S_DV : S_E1;
                end
            end
            S_DV:
            begin
                if (div_rsp.done)
                begin
                    state_next = (accel_reg && (k_reg == 2'd3)) ? S_DA : S_E1;
                end
            end
            S_DA:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_E1;
                end
            end
            S_E1:
            begin
                if (adv_emit)
                begin
                    state_next = need_flush ? S_DF : S_E3;
                end
            end
            S_DF:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_E2;
                end
            end
            S_E2:
            begin
                if (adv_emit)
                begin
                    state_next = S_E3;
                end
            end
            S_E3:
            begin
                if (adv_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign start_next = ((state_next == S_DV) || (state_next == S_DA) || (state_next == S_DF))
                      && (state_next != state_reg);

    // operands are sampled by the divider in the first cycle of each divide state
    always_comb
    begin
        unique case (state_reg)
            S_DA:
            begin
                div_req.a    = vel_reg;
                div_req.b    = vh1_reg;
                div_req.span = th0_reg - th2_reg;
            end
            S_DF:
            begin
                div_req.a    = '0;
                div_req.b    = vh0_reg;
                div_req.span = t_reg - th1_reg;
            end
            default:
            begin
                div_req.a    = p_reg;
                div_req.b    = ph1_reg;
                div_req.span = t_reg - th1_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            start_reg   <= 1'b0;
            order_reg   <= 1'b0;
            samples_reg <= 2'd0;
            ph0_reg     <= '0;
            ph1_reg     <= '0;
            th0_reg     <= '0;
            th1_reg     <= '0;
            th2_reg     <= '0;
            vh0_reg     <= '0;
            vh1_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            if (cfg_valid && cfg_ready)
            begin
                order_reg <= cfg_data;
            end
            if (update)
            begin
                // the first sample pushes no velocity, the second a zero one, later ones the computed one
                if (k_reg != 2'd0)
                begin
                    vh1_reg <= vh0_reg;
                    vh0_reg <= k_ge2 ? vel_reg : '0;
                end
                ph1_reg <= ph0_reg;
                ph0_reg <= p_reg;
                th2_reg <= th1_reg;
                th1_reg <= th0_reg;
                th0_reg <= t_reg;
                if (last_reg)
                begin
                    samples_reg <= 2'd0;
                end
                else if (k_reg != 2'd3)
                begin
                    samples_reg <= k_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p_reg     <= position;
            t_reg     <= timestamp;
            last_reg  <= end_of_trajectory;
            k_reg     <= samples_reg;
            accel_reg <= order_reg;
        end
        if (div_rsp.done)
        begin
            dq_reg  <= div_rsp.quot;
            dst_reg <= div_rsp.status;
            if (state_reg == S_DV)
            begin
                vel_reg <= div_rsp.quot;
            end
        end
    end

    ncd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ncd_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (em_valid),
        .in_ready  (em_ready),
        .in_res    (em_res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign derivative  = out_res.derivative;
    assign status      = out_res.status;
    assign last_result = out_res.last_result;

`ifndef SYNTHESIS
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != S_IDLE))
        else $error("accepted sample left the sequencer idle");

    a_accel_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DA) |-> (accel_reg && (k_reg == 2'd3)))
        else $error("acceleration divide outside interior acceleration sample");

    a_flush_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DF) |-> (accel_reg && last_reg && k_ge2))
        else $error("flush divide without final acceleration sample");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> ((state_reg == S_DV) || (state_reg == S_DA) || (state_reg == S_DF)))
        else $error("divider finished outside a divide state");
`endif

endmodule

>>> rtl/core/ncd_div.sv
// Bit-serial restoring divider: (a - b) * 2^FRAC_W / span with saturation and zero-span flag.
module ncd_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ncd_pkg::div_req_t req,
    output ncd_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic [ncd_pkg::CNT_W-1:0]     cnt_reg;
    logic                          done_reg;
    logic                          neg_reg;
    logic                          zero_reg;
    logic [ncd_pkg::DATA_W-1:0]    span_reg;
    logic [ncd_pkg::DATA_W-1:0]    rem_reg;
    logic [ncd_pkg::QUO_W-1:0]     num_reg;
    logic [ncd_pkg::DATA_W-1:0]    quot_reg;
    logic [1:0]                    st_reg;

    logic                          a_lt_b;
    logic [ncd_pkg::DATA_W-1:0]    mag;
    logic [ncd_pkg::DATA_W:0]      trial;
    logic [ncd_pkg::DATA_W:0]      trial_sub;
    logic                          take;
    logic [ncd_pkg::DATA_W-1:0]    rem_next;
    logic [ncd_pkg::DATA_W-1:0]    lo;
    logic                          sat;

    // |a - b| never exceeds 2^DATA_W - 1, so the wrapped difference is exact
    assign a_lt_b = $signed(req.a) < $signed(req.b);
    assign mag    = a_lt_b ? (req.b - req.a) : (req.a - req.b);

    assign trial     = {rem_reg, num_reg[ncd_pkg::QUO_W-1]};
    assign trial_sub = trial - {1'b0, span_reg};
    assign take      = trial >= {1'b0, span_reg};
    assign rem_next  = take ? trial_sub[ncd_pkg::DATA_W-1:0] : trial[ncd_pkg::DATA_W-1:0];

    // quotient bits shift into the low end of num_reg as the dividend leaves the top
    assign lo  = num_reg[ncd_pkg::DATA_W-1:0];
    assign sat = (|num_reg[ncd_pkg::QUO_W-1:ncd_pkg::DATA_W])
               || (lo[ncd_pkg::DATA_W-1] && (!neg_reg || (|lo[ncd_pkg::DATA_W-2:0])));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (req.span == '0) ? '0 : ncd_pkg::CNT_W'(ncd_pkg::QUO_W);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= a_lt_b;
            zero_reg <= (req.span == '0);
            span_reg <= req.span;
            rem_reg  <= '0;
            num_reg  <= {mag, {ncd_pkg::FRAC_W{1'b0}}};
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[ncd_pkg::QUO_W-2:0], take};
        end
        else if (busy_reg)
        begin
            if (zero_reg)
            begin
                quot_reg <= '0;
                st_reg   <= ncd_pkg::ST_ZERO;
            end
            else if (sat)
            begin
                quot_reg <= neg_reg ? ncd_pkg::D_MIN : ncd_pkg::D_MAX;
                st_reg   <= ncd_pkg::ST_SAT;
            end
            else
            begin
                quot_reg <= neg_reg ? (~lo + 1'b1) : lo;
                st_reg   <= ncd_pkg::ST_OK;
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.quot   = quot_reg;
    assign rsp.status = st_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not go busy after start");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (st_reg == ncd_pkg::ST_ZERO)) |-> (quot_reg == '0))
        else $error("zero span gave nonzero quotient");

    a_sat_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (st_reg == ncd_pkg::ST_SAT))
            |-> ((quot_reg == ncd_pkg::D_MAX) || (quot_reg == ncd_pkg::D_MIN)))
        else $error("saturated quotient not at a bound");
`endif

endmodule

>>> rtl/core/ncd_obuf.sv
// Output register stage that decouples result production from the downstream receiver.
module ncd_obuf
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ncd_pkg::res_t in_res,
    output logic          out_valid,
    input  logic          out_ready,
    output ncd_pkg::res_t out_res
);

    logic          full_reg;
    ncd_pkg::res_t data_reg;

    assign in_ready  = !full_reg || out_ready;
    assign out_valid = full_reg;
    assign out_res   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            full_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_res;
        end
    end

endmodule
